FILE: hdl/ils_pkg.sv
// shared widths, opcodes and status codes for the indexed list store
package ils_pkg;

    localparam int ACT_W   = 3;
    localparam int POS_W   = 11;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int COUNT_W = 11;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = M_TDATA_W - COUNT_W - ST_W - VAL_W;

    typedef logic [ACT_W-1:0] action_t;
    typedef logic [ST_W-1:0]  status_t;

    localparam action_t ACT_READ = 3'd0;
    localparam action_t ACT_HEAD = 3'd1;
    localparam action_t ACT_TAIL = 3'd2;
    localparam action_t ACT_AT   = 3'd3;
    localparam action_t ACT_DEL  = 3'd4;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    localparam logic [VAL_W-1:0] NO_VALUE = '1;

endpackage

FILE: hdl/indexed_list_store_top.sv
// indexed list store: sequencer shifting elements through one memory, one item at a time
// path to result valid: EXEC, S_OUT if rejected or no-op; EXEC, RDCAP, S_OUT for a read;
// an insert at p with n stored moves n-p elements and a delete at p moves n-1-p, each
// by a memory read and a write in INSRD/INSWR or DELRD/DELWR, then S_OUT; input is taken
// only in IDLE, and an item waits in S_OUT while the previous result is stalled
// reset: synchronous active-low aresetn empties the list; memory contents are not cleared
module indexed_list_store_top
    import ils_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // action[2:0], position[13:3], value[45:14]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // read_value[31:0], status[33:32], count[44:34]
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_RDCAP = 3'd2;
    localparam logic [2:0] S_INSRD = 3'd3;
    localparam logic [2:0] S_INSWR = 3'd4;
    localparam logic [2:0] S_DELRD = 3'd5;
    localparam logic [2:0] S_DELWR = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]           state_reg, state_next;
    action_t              act_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [AW-1:0]        p_reg, p_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [VAL_W-1:0]     res_val_reg, res_val_next;
    status_t              res_st_reg, res_st_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [VAL_W-1:0] mem [CAPACITY];
    logic [VAL_W-1:0] rd_data_reg;
    logic [AW-1:0]    mem_raddr;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_we;

    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic          full;
    logic          s_accept;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign pos_ext = PW'(pos_reg);
    assign cnt_ext = PW'(cnt_reg);
    assign full    = (cnt_reg == CAP_COUNT);

    always_comb begin
        state_next   = state_reg;
        p_next       = p_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        mem_raddr    = idx_reg;
        mem_waddr    = idx_reg;
        mem_wdata    = rd_data_reg;
        mem_we       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_val_next = NO_VALUE;
                res_st_next  = ST_DONE;
                state_next   = S_OUT;
                case (act_reg)
                    ACT_READ: begin
                        if (pos_ext < cnt_ext) begin
                            mem_raddr  = AW'(pos_reg);
                            state_next = S_RDCAP;
                        end else begin
                            res_st_next = ST_RANGE;
                        end
                    end
                    ACT_HEAD: begin
                        if (full) begin
                            res_st_next = ST_FULL;
                        end else begin
                            p_next     = '0;
                            idx_next   = AW'(cnt_reg);
                            state_next = S_INSRD;
                        end
                    end
                    ACT_TAIL: begin
                        if (full) begin
                            res_st_next = ST_FULL;
                        end else begin
                            p_next     = AW'(cnt_reg);
                            idx_next   = AW'(cnt_reg);
                            state_next = S_INSRD;
                        end
                    end
                    ACT_AT: begin
                        if (pos_ext > cnt_ext) begin
                            res_st_next = ST_RANGE;
                        end else if (full) begin
                            res_st_next = ST_FULL;
                        end else begin
                            p_next     = AW'(pos_reg);
                            idx_next   = AW'(cnt_reg);
                            state_next = S_INSRD;
                        end
                    end
                    ACT_DEL: begin
                        if (pos_ext >= cnt_ext) begin
                            res_st_next = ST_RANGE;
                        end else begin
                            idx_next   = AW'(pos_reg);
                            state_next = S_DELRD;
                        end
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_RDCAP: begin
                res_val_next = rd_data_reg;
                state_next   = S_OUT;
            end
            S_INSRD: begin
                // walk from the tail down to the insert point, one element per pass
                if (idx_reg == p_reg) begin
                    mem_we     = 1'b1;
                    mem_waddr  = p_reg;
                    mem_wdata  = val_reg;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_OUT;
                end else begin
                    mem_raddr  = idx_reg - AW'(1);
                    state_next = S_INSWR;
                end
            end
            S_INSWR: begin
                mem_we     = 1'b1;
                idx_next   = idx_reg - AW'(1);
                state_next = S_INSRD;
            end
            S_DELRD: begin
                if (CW'(idx_reg) + CW'(1) == cnt_reg) begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_OUT;
                end else begin
                    mem_raddr  = idx_reg + AW'(1);
                    state_next = S_DELWR;
                end
            end
            S_DELWR: begin
                mem_we     = 1'b1;
                idx_next   = idx_reg + AW'(1);
                state_next = S_DELRD;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{M_PAD_W{1'b0}}, COUNT_W'(cnt_reg), res_st_reg,
                                    res_val_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg <= s_tdata[ACT_W-1:0];
            pos_reg <= s_tdata[ACT_W +: POS_W];
            val_reg <= s_tdata[ACT_W+POS_W +: VAL_W];
        end
        p_reg       <= p_next;
        idx_reg     <= idx_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        m_data_reg  <= m_data_next;
    end

    // element memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule

FILE: hdl/ils_checker.sv
// port-level checks for the indexed list store, bound to the top level
module ils_checker
    import ils_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata   // read_value[31:0], status[33:32], count[44:34]
);

    logic [VAL_W-1:0]   rd_val;
    status_t            st;
    logic [COUNT_W-1:0] cnt;
    logic [COUNT_W-1:0] last_cnt_reg;
    logic               seen_reg;
    logic               s_accept;
    logic               m_accept;

    assign rd_val   = m_tdata[VAL_W-1:0];
    assign st       = m_tdata[VAL_W +: ST_W];
    assign cnt      = m_tdata[VAL_W+ST_W +: COUNT_W];
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (m_accept) begin
            seen_reg <= 1'b1;
        end
        if (m_accept) begin
            last_cnt_reg <= cnt;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input taken again while an item is in work");

    a_fail_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st != ST_DONE |-> rd_val == NO_VALUE && (st == ST_RANGE || st == ST_FULL))
        else $error("failed transaction carries a read value");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == ST_FULL |-> cnt == COUNT_W'(CAPACITY))
        else $error("full status with list not at capacity");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_accept && seen_reg |-> cnt == last_cnt_reg || cnt == last_cnt_reg + COUNT_W'(1)
            || cnt + COUNT_W'(1) == last_cnt_reg)
        else $error("count moved by more than one between results");

endmodule

bind indexed_list_store_top ils_checker #(.CAPACITY(CAPACITY)) u_ils_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
